[sv/rld_pkg.sv]
// Package for the block run-length decoder: constants, controller states,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package rld_pkg;

  localparam int LanesDefault = 8;
  localparam int MaxResults = 32;
  localparam int ByteW = 8;
  localparam int CopiesW = 4;
  localparam int LenW = 16;
  localparam int AddrW = 3;
  localparam logic [LenW-1:0] MaxLenReset = 16'd512;
  localparam logic RegMaxBlockLen = 1'b0;

  typedef enum logic [2:0] {
    ST_HIGH,
    ST_LOW,
    ST_COUNT,
    ST_SYMBOL,
    ST_RUN
  } rld_state_t;

  typedef struct packed {
    logic ld_high;
    logic ld_len;
    logic ld_count;
    logic ld_sym;
    logic run_beat;
    logic push;
    logic push_err;
    logic push_last;
  } rld_cmd_t;

  typedef struct packed {
    logic out_free;
    logic len_bad;
    logic rem_one;
    logic rem_zero;
    logic count_zero;
    logic first_last;
    logic run_last;
  } rld_status_t;

endpackage

[sv/rld_in_if.sv]
// Valid/ready channel that carries one compressed stream byte per beat.
// Depends on rld_pkg.
interface rld_in_if;
  logic                      valid;
  logic                      ready;
  logic [rld_pkg::ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

[sv/rld_out_if.sv]
// Valid/ready channel that carries one decoded beat of repeated bytes.
// Depends on rld_pkg.
interface rld_out_if;
  logic                        valid;
  logic                        ready;
  logic [rld_pkg::ByteW-1:0]   symbol;
  logic [rld_pkg::CopiesW-1:0] copies;
  logic                        bad_length;
  logic                        last;

  modport source (output valid, output symbol, output copies, output bad_length,
                  output last, input ready);
  modport sink (input valid, input symbol, input copies, input bad_length,
                input last, output ready);
endinterface

[sv/rld_ctrl.sv]
// Controller of the decoder: tracks the stream phase and sequences the beats
// of a long run. Depends on rld_pkg.
module rld_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rld_pkg::rld_status_t sts,
  output rld_pkg::rld_cmd_t    cmd
);

  rld_pkg::rld_state_t state;
  rld_pkg::rld_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rld_pkg::ST_HIGH;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      rld_pkg::ST_HIGH: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_high = 1'b1;
          state_next  = rld_pkg::ST_LOW;
        end
      end
      rld_pkg::ST_LOW: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (sts.len_bad) begin
            cmd.push      = 1'b1;
            cmd.push_err  = 1'b1;
            cmd.push_last = 1'b1;
            state_next    = rld_pkg::ST_HIGH;
          end else begin
            cmd.ld_len = 1'b1;
            state_next = rld_pkg::ST_COUNT;
          end
        end
      end
      rld_pkg::ST_COUNT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_count = 1'b1;
          state_next   = sts.rem_one ? rld_pkg::ST_HIGH : rld_pkg::ST_SYMBOL;
        end
      end
      rld_pkg::ST_SYMBOL: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.ld_sym    = 1'b1;
          cmd.push      = !sts.count_zero;
          cmd.push_last = sts.first_last;
          if (sts.count_zero || sts.first_last) begin
            state_next = sts.rem_one ? rld_pkg::ST_HIGH : rld_pkg::ST_COUNT;
          end else begin
            state_next = rld_pkg::ST_RUN;
          end
        end
      end
      rld_pkg::ST_RUN: begin
        if (sts.out_free) begin
          cmd.run_beat  = 1'b1;
          cmd.push      = 1'b1;
          cmd.push_last = sts.run_last;
          if (sts.run_last) begin
            state_next = sts.rem_zero ? rld_pkg::ST_HIGH : rld_pkg::ST_COUNT;
          end
        end
      end
      default: begin
        state_next = rld_pkg::ST_HIGH;
      end
    endcase
  end

endmodule

[sv/rld_datapath.sv]
// Datapath of the decoder: header and block counters, run bookkeeping and
// the output register. Depends on rld_pkg.
module rld_datapath #(
  parameter int LANES = rld_pkg::LanesDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rld_pkg::rld_cmd_t           cmd,
  output rld_pkg::rld_status_t        sts,
  input  logic [rld_pkg::ByteW-1:0]   byte_in,
  input  logic [rld_pkg::LenW-1:0]    max_block_len,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [rld_pkg::ByteW-1:0]   symbol,
  output logic [rld_pkg::CopiesW-1:0] copies,
  output logic                        bad_length,
  output logic                        last
);

  localparam int BeatW = $clog2(rld_pkg::MaxResults + 1);
  localparam logic [rld_pkg::ByteW-1:0] LanesB = rld_pkg::ByteW'(LANES);
  localparam logic [BeatW-1:0] LastBeat = BeatW'(rld_pkg::MaxResults - 1);

  logic [rld_pkg::ByteW-1:0] length_high;
  logic [rld_pkg::LenW-1:0]  block_remaining;
  logic [rld_pkg::ByteW-1:0] pending_count;
  logic [rld_pkg::ByteW-1:0] left;
  logic [rld_pkg::ByteW-1:0] run_symbol;
  logic [BeatW-1:0]          beat_cnt;

  logic [rld_pkg::LenW-1:0]  header_len;
  logic [rld_pkg::ByteW-1:0] cp_first;
  logic [rld_pkg::ByteW-1:0] cp_run;

  assign header_len = {length_high, byte_in};
  assign cp_first   = (pending_count >= LanesB) ? LanesB : pending_count;
  assign cp_run     = (left >= LanesB) ? LanesB : left;

  assign sts.out_free   = !out_valid || out_ready;
  assign sts.len_bad    = (header_len == '0) || (header_len > max_block_len);
  assign sts.rem_one    = (block_remaining == rld_pkg::LenW'(1));
  assign sts.rem_zero   = (block_remaining == '0);
  assign sts.count_zero = (pending_count == '0);
  assign sts.first_last = (pending_count <= LanesB);
  assign sts.run_last   = (left <= LanesB) || (beat_cnt == LastBeat);

  always_ff @(posedge clk) begin
    if (cmd.ld_high) begin
      length_high <= byte_in;
    end
    if (cmd.ld_len) begin
      block_remaining <= header_len;
    end else if (cmd.ld_count || cmd.ld_sym) begin
      block_remaining <= block_remaining - rld_pkg::LenW'(1);
    end
    if (cmd.ld_count) begin
      pending_count <= byte_in;
    end
    if (cmd.ld_sym) begin
      run_symbol <= byte_in;
      left       <= pending_count - cp_first;
      beat_cnt   <= BeatW'(1);
    end else if (cmd.run_beat) begin
      left     <= left - cp_run;
      beat_cnt <= beat_cnt + BeatW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      bad_length <= cmd.push_err;
      last       <= cmd.push_last;
      if (cmd.push_err) begin
        symbol <= '0;
        copies <= '0;
      end else if (cmd.ld_sym) begin
        symbol <= byte_in;
        copies <= cp_first[rld_pkg::CopiesW-1:0];
      end else begin
        symbol <= run_symbol;
        copies <= cp_run[rld_pkg::CopiesW-1:0];
      end
    end
  end

endmodule

[sv/block_rle_decoder_top.sv]
// Top level of the block run-length decoder: configuration register, controller
// and datapath. Depends on rld_pkg, rld_in_if, rld_out_if, rld_ctrl, rld_datapath.
//
//   Channel   Role    Beat contents
//   stream    sink    byte_in: one compressed stream byte
//   decoded   source  symbol, copies, bad_length, last: one decoded beat
//   APB       slave   max_block_len at byte address 0
//
// A symbol byte yields ceil(count / LANES) beats with at most 32, and no beat for a
// zero count, as the controller steps one beat per cycle into the output register
// whenever that register is free.
// Reset is synchronous and clears the controller and the output valid.
// A stalled output register holds off header low bytes and symbol bytes.
module block_rle_decoder_top #(
  parameter int LANES = rld_pkg::LanesDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  rld_in_if.sink                      stream,
  rld_out_if.source                   decoded,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rld_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [rld_pkg::LenW-1:0] max_block_len;
  logic                     cfg_write;
  rld_pkg::rld_cmd_t        cmd;
  rld_pkg::rld_status_t     sts;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_block_len <= rld_pkg::MaxLenReset;
    end else if (cfg_write && (paddr[2] == rld_pkg::RegMaxBlockLen)) begin
      max_block_len <= pwdata[rld_pkg::LenW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == rld_pkg::RegMaxBlockLen) begin
      prdata = {16'b0, max_block_len};
    end
  end

  rld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_ready (stream.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rld_datapath #(
    .LANES (LANES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .byte_in       (stream.byte_in),
    .max_block_len (max_block_len),
    .out_ready     (decoded.ready),
    .out_valid     (decoded.valid),
    .symbol        (decoded.symbol),
    .copies        (decoded.copies),
    .bad_length    (decoded.bad_length),
    .last          (decoded.last)
  );

endmodule

[sv/rld_checker.sv]
// Port-level checks for the block run-length decoder, bound to the top level.
// Depends on rld_pkg and block_rle_decoder_top.
module rld_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_ready,
  input logic                        d_valid,
  input logic                        d_ready,
  input logic [rld_pkg::ByteW-1:0]   d_symbol,
  input logic [rld_pkg::CopiesW-1:0] d_copies,
  input logic                        d_bad_length,
  input logic                        d_last
);

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    d_valid && d_bad_length |-> d_copies == '0 && d_symbol == '0 && d_last)
    else $error("Error beat carries data or is not last.");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    d_valid && !d_last |-> !s_ready)
    else $error("Stream byte offered while a run is still being emitted.");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !d_valid)
    else $error("Decoded valid high right after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    d_valid && !d_ready |=> d_valid && $stable(d_symbol) && $stable(d_copies)
      && $stable(d_bad_length) && $stable(d_last))
    else $error("Stalled decoded beat changed.");

endmodule

bind block_rle_decoder_top rld_checker u_rld_checker (
  .clk          (clk),
  .rst          (rst),
  .s_ready      (stream.ready),
  .d_valid      (decoded.valid),
  .d_ready      (decoded.ready),
  .d_symbol     (decoded.symbol),
  .d_copies     (decoded.copies),
  .d_bad_length (decoded.bad_length),
  .d_last       (decoded.last)
);

[verif/block_rle_decoder_checker.sv]
// Scoreboard for the block run-length decoder: follows the block headers and
// run pairs of the byte stream and checks every decoded beat against them.
// Depends on rld_pkg, rld_in_if and rld_out_if.
module block_rle_decoder_checker
  import rld_pkg::*;
#(
  parameter int               LANES        = LanesDefault,
  parameter logic [AddrW-1:0] MAX_LEN_ADDR = '0
) (
  input  logic             clk,
  input  logic             rst,
  rld_in_if                stream,
  rld_out_if               decoded,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output int               mismatches,
  output int               beats_pending,
  output int               bytes_taken,
  output int               beats_taken,
  output int               length_errors
);

  typedef enum logic [1:0] {
    HDR_HIGH,
    HDR_LOW,
    RUN_COUNT,
    RUN_SYMBOL
  } parse_phase_t;

  typedef struct packed {
    logic [ByteW-1:0]   symbol;
    logic [CopiesW-1:0] copies;
    logic               bad_length;
    logic               last;
  } beat_t;

  beat_t            expected_beats[$];
  parse_phase_t     phase;
  logic [ByteW-1:0] len_high;
  logic [ByteW-1:0] run_count;
  logic [LenW-1:0]  remaining;
  logic [LenW-1:0]  max_len;

  task automatic report(input string what);
    $display("[%0t] decoder check: %s", $time, what);
    mismatches++;
  endtask

  function automatic void decode_byte(input logic [ByteW-1:0] b);
    int    left;
    int    n_beats;
    int    cp;
    beat_t beat;
    case (phase)
      HDR_HIGH: begin
        len_high = b;
        phase = HDR_LOW;
      end
      HDR_LOW: begin
        if ({len_high, b} == '0 || {len_high, b} > max_len) begin
          beat.symbol = '0;
          beat.copies = '0;
          beat.bad_length = 1'b1;
          beat.last = 1'b1;
          expected_beats.push_back(beat);
          phase = HDR_HIGH;
        end else begin
          remaining = {len_high, b};
          phase = RUN_COUNT;
        end
      end
      RUN_COUNT: begin
        run_count = b;
        remaining = remaining - 1'b1;
        phase = (remaining == '0) ? HDR_HIGH : RUN_SYMBOL;
      end
      default: begin
        remaining = remaining - 1'b1;
        phase = (remaining == '0) ? HDR_HIGH : RUN_COUNT;
        left = int'(run_count);
        n_beats = (left + LANES - 1) / LANES;
        if (n_beats > MaxResults) begin
          n_beats = MaxResults;
        end
        for (int k = 0; k < n_beats; k++) begin
          cp = (left < LANES) ? left : LANES;
          left -= cp;
          beat.symbol = b;
          beat.copies = CopiesW'(cp);
          beat.bad_length = 1'b0;
          beat.last = (k == n_beats - 1);
          expected_beats.push_back(beat);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      phase = HDR_HIGH;
      len_high = '0;
      run_count = '0;
      remaining = '0;
      max_len = MaxLenReset;
      expected_beats.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == MAX_LEN_ADDR) begin
        max_len = pwdata[LenW-1:0];
      end
      if (stream.valid && stream.ready) begin
        bytes_taken++;
        decode_byte(stream.byte_in);
      end
      if (decoded.valid && decoded.ready) begin
        beats_taken++;
        if (decoded.bad_length) begin
          length_errors++;
        end
        if (expected_beats.size() == 0) begin
          report($sformatf("unexpected beat: symbol %02h copies %0d bad_length %0b last %0b",
                           decoded.symbol, decoded.copies, decoded.bad_length,
                           decoded.last));
        end else begin
          want = expected_beats.pop_front();
          if (decoded.symbol !== want.symbol || decoded.copies !== want.copies ||
              decoded.bad_length !== want.bad_length || decoded.last !== want.last) begin
            report($sformatf({"beat %0d: got symbol %02h copies %0d bad_length %0b last %0b,",
                              " expected %02h %0d %0b %0b"}, beats_taken,
                             decoded.symbol, decoded.copies, decoded.bad_length,
                             decoded.last, want.symbol, want.copies, want.bad_length,
                             want.last));
          end
        end
      end
    end
    beats_pending <= expected_beats.size();
  end

endmodule

[verif/block_rle_decoder_top_tb.sv]
// Testbench top for the block run-length decoder: drives compressed bytes and
// max_block_len writes under several idle and stall mixes, then gives the verdict.
// Depends on rld_pkg, rld_in_if, rld_out_if, block_rle_decoder_top and the checker.
module block_rle_decoder_top_tb;
  import rld_pkg::*;

  localparam int               Lanes      = LanesDefault;
  localparam int               IdleLimit  = 2000;
  localparam logic [AddrW-1:0] MaxLenAddr = AddrW'(4 * int'(RegMaxBlockLen));

  logic             clk;
  logic             rst;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  int               send_idle_pct;
  int               recv_stall_pct;
  int               idle_cycles;
  int               settings_used;
  int               mismatches;
  int               beats_pending;
  int               bytes_taken;
  int               beats_taken;
  int               length_errors;
  logic [ByteW-1:0] byte_q[$];

  rld_in_if  stream_ch ();
  rld_out_if decoded_ch ();

  block_rle_decoder_top #(
    .LANES(Lanes)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch),
    .decoded (decoded_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  block_rle_decoder_checker #(
    .LANES       (Lanes),
    .MAX_LEN_ADDR(MaxLenAddr)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .stream       (stream_ch),
    .decoded      (decoded_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .beats_pending(beats_pending),
    .bytes_taken  (bytes_taken),
    .beats_taken  (beats_taken),
    .length_errors(length_errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    decoded_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((stream_ch.valid && stream_ch.ready) || (decoded_ch.valid && decoded_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("block_rle_decoder_top_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_max_len(input int unsigned value);
    apb_write(MaxLenAddr, 32'(value));
    settings_used++;
  endtask

  // Holds the stream off until every predicted beat has come out.
  task automatic settle();
    stream_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      stream_ch.valid <= 1'b0;
      @(posedge clk);
    end
    stream_ch.valid <= 1'b1;
    stream_ch.byte_in <= b;
    @(posedge clk);
    while (!stream_ch.ready) @(posedge clk);
  endtask

  task automatic send_bytes(input int pause_at);
    int k = 0;
    while (byte_q.size() > 0) begin
      if (k == pause_at) begin
        settle();
      end
      send_byte(byte_q.pop_front());
      k++;
    end
    settle();
  endtask

  function automatic logic [ByteW-1:0] pick_run_count();
    int r;
    r = int'($urandom_range(99));
    if (r < 12) return '0;
    if (r < 60) return ByteW'($urandom_range(1, 16));
    if (r < 88) return ByteW'($urandom_range(17, 64));
    if (r < 95) return ByteW'($urandom_range(65, 254));
    return '1;
  endfunction

  function automatic void add_header(input int unsigned len);
    byte_q.push_back(ByteW'(len >> 8));
    byte_q.push_back(ByteW'(len));
  endfunction

  function automatic void add_pairs(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      byte_q.push_back((i % 2 == 0) ? pick_run_count() : ByteW'($urandom_range(255)));
    end
  endfunction

  // Mostly well-formed blocks with random pairs, plus bad headers and noise.
  function automatic void add_random_blocks(input int n_bytes, input int unsigned max_len);
    int          r;
    int          target;
    int unsigned cap;
    int unsigned len;
    target = byte_q.size() + n_bytes;
    cap = (max_len == 0 || max_len > 24) ? 24 : max_len;
    while (byte_q.size() < target) begin
      r = int'($urandom_range(99));
      if (r < 8) begin
        add_header(0);
      end else if (r < 16 && max_len < 65535) begin
        add_header(max_len + 1);
      end else if (r < 22) begin
        byte_q.push_back(ByteW'($urandom_range(255)));
        byte_q.push_back(ByteW'($urandom_range(255)));
      end else begin
        len = (r < 30 && max_len != 0 && max_len <= 40) ? max_len : $urandom_range(1, cap);
        add_header(len);
        add_pairs(len);
      end
    end
  endfunction

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    stream_ch.valid <= 1'b0;
    stream_ch.byte_in <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Zero length, one past the limit, the widest header, long and empty runs,
    // and a block that ends on a count byte.
    add_header(0);
    add_header(513);
    add_header(16'hFFFF);
    add_header(6);
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'h00);
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hAB);
    byte_q.push_back(8'h09);
    byte_q.push_back(8'hFF);
    add_header(3);
    byte_q.push_back(8'h08);
    byte_q.push_back(8'h5A);
    byte_q.push_back(8'h07);
    add_header(4);
    byte_q.push_back(8'h01);
    byte_q.push_back(8'h81);
    byte_q.push_back(8'h10);
    byte_q.push_back(8'h7E);
    add_random_blocks(40, 512);
    send_bytes(-1);

    set_max_len(1);
    send_idle_pct = 78;
    add_random_blocks(25, 1);
    send_bytes(-1);

    set_max_len(40);
    send_idle_pct = 0;
    recv_stall_pct = 78;
    add_random_blocks(45, 40);
    send_bytes(-1);

    set_max_len(0);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    add_random_blocks(15, 0);
    send_bytes(-1);

    set_max_len(300);
    add_random_blocks(40, 300);
    send_bytes(25);

    // Largest limit last, since the accepted block never ends.
    set_max_len(65535);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_header(65535);
    add_pairs(10);
    send_bytes(-1);

    $display("Run covered %0d stream bytes and %0d decoded beats, %0d of them length errors,",
             bytes_taken, beats_taken, length_errors);
    $display("over %0d max_block_len settings and four idle and stall mixes.", settings_used);
    if (mismatches == 0 && beats_pending == 0) begin
      $display("block_rle_decoder_top_tb OK");
    end else begin
      $display("block_rle_decoder_top_tb NOT OK");
    end
    $finish;
  end

endmodule
